### hw/rtl/sfrp_pkg.sv
// ----------------------------------------------------------------------------
// sfrp_pkg: shared types and constants of the status frame parser
// Event codes, datapath commands and status, and the controller states.
// ----------------------------------------------------------------------------
package sfrp_pkg;

	localparam int MEM_DEPTH            = 32;
	localparam int PTR_W                = 5;
	localparam int FILL_W               = 6;
	localparam int MAGIC_BYTES          = 4;
	localparam int HDR_BYTES            = 8;
	localparam int STATUS_PAYLOAD_BYTES = 14;
	localparam int FRAME_OVERHEAD       = 9;
	localparam int FRAME_BYTES          = FRAME_OVERHEAD + STATUS_PAYLOAD_BYTES;
	// frame bytes held from the sequence byte on
	localparam int CAP_BYTES            = FRAME_BYTES - MAGIC_BYTES;
	localparam int CAP_W                = 5;
	localparam int CFG_IDX_W            = 2;
	localparam int CFG_DATA_W           = 32;

	localparam logic [CFG_IDX_W-1:0] REG_MAGIC   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COMMAND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 2'd2;

	typedef enum logic [2:0] {
		KIND_STATUS,
		KIND_NOISE,
		KIND_OVERSIZE,
		KIND_COMMAND,
		KIND_LENGTH,
		KIND_CHECKSUM
	} kind_t;

	typedef enum logic [2:0] {
		DROP_NONE,
		DROP_ONE,
		DROP_POS,
		DROP_DISC,
		DROP_FRAME
	} drop_t;

	typedef enum logic [2:0] {
		J_HOLD,
		J_CLR,
		J_INC,
		J_SET4,
		J_SET8
	} j_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_NOMATCH,
		ST_FOUND,
		ST_FRM_RD,
		ST_FRM_CAP,
		ST_CHECK,
		ST_SUM,
		ST_LOOP,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic  accept;
		j_op_t j_op;
		logic  rd;
		logic  shift;
		logic  cap;
		drop_t drop;
		logic  emit;
		kind_t kind;
		logic  flush;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic fill_zero;
		logic j_at_fill;
		logic hit;
		logic disc_nz;
		logic pos_nz;
		logic rem_short;
		logic frame_short;
		logic len_over;
		logic cmd_bad;
		logic len_bad;
		logic sum_bad;
		logic room;
		logic out_free;
		logic pend_v;
		logic j_hdr_end;
		logic j_frm_end;
	} stat_t;

	typedef struct packed {
		kind_t       kind;
		logic [5:0]  noise;
		logic [7:0]  seq;
		logic [15:0] buttons;
		logic [15:0] lt;
		logic [15:0] rt;
		logic [15:0] lx;
		logic [15:0] ly;
		logic [15:0] rx;
		logic [15:0] ry;
	} evt_t;

endpackage

### hw/rtl/sfrp_if.sv
// ----------------------------------------------------------------------------
// sfrp channel interfaces
// Received byte channel and event channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfrp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

interface sfrp_event_if;
	logic               valid;
	logic               ready;
	logic [2:0]         event_kind;
	logic [5:0]         noise_count;
	logic [7:0]         sequence_res;
	logic [15:0]        buttons;
	logic [15:0]        trigger_l;
	logic [15:0]        trigger_r;
	logic signed [15:0] left_x;
	logic signed [15:0] left_y;
	logic signed [15:0] right_x;
	logic signed [15:0] right_y;
	logic               last_event;
	modport source(output valid, output event_kind, output noise_count, output sequence_res,
		output buttons, output trigger_l, output trigger_r, output left_x,
		output left_y, output right_x, output right_y, output last_event, input ready);
	modport sink(input valid, input event_kind, input noise_count, input sequence_res,
		input buttons, input trigger_l, input trigger_r, input left_x,
		input left_y, input right_x, input right_y, input last_event, output ready);
endinterface

### hw/rtl/sfrp_datapath.sv
// ----------------------------------------------------------------------------
// sfrp_datapath: byte ring, scan window, frame capture and event registers
// Executes the controller's commands and reports status flags back.
// ----------------------------------------------------------------------------
module sfrp_datapath #(
	parameter int BUFFER_BYTES = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [7:0]                          in_byte,
	input  logic                                wr_en,
	input  logic [sfrp_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [sfrp_pkg::CFG_DATA_W-1:0]     wr_data,
	input  sfrp_pkg::cmd_t                      cmd,
	output sfrp_pkg::stat_t                     stat,
	sfrp_event_if.source                        events
);

	logic [7:0] mem [sfrp_pkg::MEM_DEPTH];
	logic [7:0] cap_q [sfrp_pkg::CAP_BYTES];

	logic [31:0]                       magic_q;
	logic [7:0]                        status_cmd_q;
	logic [15:0]                       max_payload_q;
	logic [sfrp_pkg::PTR_W-1:0]        head_q;
	logic [sfrp_pkg::FILL_W-1:0]       fill_q;
	logic [sfrp_pkg::FILL_W-1:0]       j_q;
	logic [31:0]                       win_q;
	logic [7:0]                        rdata_q;
	sfrp_pkg::evt_t                    pend_q;
	logic                              pend_v_q;
	sfrp_pkg::evt_t                    out_q;
	logic                              out_v_q;
	logic                              out_last_q;

	logic [31:0]                       win_next;
	logic [1:0]                        keep;
	logic [sfrp_pkg::FILL_W-1:0]       disc;
	logic [sfrp_pkg::FILL_W-1:0]       pos;
	logic [sfrp_pkg::FILL_W-1:0]       amt;
	logic [15:0]                       len;
	logic [7:0]                        sum;
	logic [sfrp_pkg::CAP_W-1:0]        cap_idx;
	logic [sfrp_pkg::PTR_W-1:0]        rd_addr;
	logic [sfrp_pkg::PTR_W-1:0]        wr_addr;
	logic                              out_free;
	sfrp_pkg::evt_t                    ev;

	assign win_next = {rdata_q, win_q[31:8]};
	assign pos      = j_q - sfrp_pkg::FILL_W'(sfrp_pkg::MAGIC_BYTES - 1);
	assign disc     = fill_q - {4'd0, keep};
	assign len      = {cap_q[3], cap_q[2]};
	assign cap_idx  = sfrp_pkg::CAP_W'(j_q - sfrp_pkg::FILL_W'(sfrp_pkg::MAGIC_BYTES));
	assign rd_addr  = head_q + j_q[sfrp_pkg::PTR_W-1:0];
	assign wr_addr  = head_q + fill_q[sfrp_pkg::PTR_W-1:0];
	assign out_free = !out_v_q || events.ready;

	// longest tail of the buffer that starts the magic
	always_comb begin
		if (fill_q >= 6'd3 && win_q[31:8] == magic_q[23:0]) begin
			keep = 2'd3;
		end else if (fill_q >= 6'd2 && win_q[31:16] == magic_q[15:0]) begin
			keep = 2'd2;
		end else if (fill_q >= 6'd1 && win_q[31:24] == magic_q[7:0]) begin
			keep = 2'd1;
		end else begin
			keep = 2'd0;
		end
	end

	always_comb begin
		sum = 8'd0;
		for (int i = 0; i < sfrp_pkg::CAP_BYTES - 1; i++) begin
			sum = sum ^ cap_q[i];
		end
	end

	always_comb begin
		case (cmd.drop)
			sfrp_pkg::DROP_ONE:   amt = 6'd1;
			sfrp_pkg::DROP_POS:   amt = pos;
			sfrp_pkg::DROP_DISC:  amt = disc;
			sfrp_pkg::DROP_FRAME: amt = sfrp_pkg::FILL_W'(sfrp_pkg::FRAME_BYTES);
			default:              amt = 6'd0;
		endcase
	end

	always_comb begin
		ev      = '0;
		ev.kind = cmd.kind;
		if (cmd.kind == sfrp_pkg::KIND_NOISE) begin
			ev.noise = amt;
		end
		if (cmd.kind == sfrp_pkg::KIND_STATUS) begin
			ev.seq     = cap_q[0];
			ev.buttons = {cap_q[5], cap_q[4]};
			ev.lt      = {cap_q[7], cap_q[6]};
			ev.rt      = {cap_q[9], cap_q[8]};
			ev.lx      = {cap_q[11], cap_q[10]};
			ev.ly      = {cap_q[13], cap_q[12]};
			ev.rx      = {cap_q[15], cap_q[14]};
			ev.ry      = {cap_q[17], cap_q[16]};
		end
	end

	always_comb begin
		stat.full        = fill_q == sfrp_pkg::FILL_W'(BUFFER_BYTES);
		stat.fill_zero   = fill_q == 6'd0;
		stat.j_at_fill   = j_q == fill_q;
		stat.hit         = (j_q >= 6'd3) && (win_next == magic_q);
		stat.disc_nz     = disc != 6'd0;
		stat.pos_nz      = pos != 6'd0;
		stat.rem_short   = (fill_q - pos) < sfrp_pkg::FILL_W'(sfrp_pkg::HDR_BYTES);
		stat.frame_short = fill_q < sfrp_pkg::FILL_W'(sfrp_pkg::FRAME_BYTES);
		stat.len_over    = len > max_payload_q;
		stat.cmd_bad     = cap_q[1] != status_cmd_q;
		stat.len_bad     = len != 16'(sfrp_pkg::STATUS_PAYLOAD_BYTES);
		stat.sum_bad     = sum != cap_q[sfrp_pkg::CAP_BYTES-1];
		stat.room        = !pend_v_q || out_free;
		stat.out_free    = out_free;
		stat.pend_v      = pend_v_q;
		stat.j_hdr_end   = j_q == sfrp_pkg::FILL_W'(sfrp_pkg::HDR_BYTES - 1);
		stat.j_frm_end   = j_q == sfrp_pkg::FILL_W'(sfrp_pkg::FRAME_BYTES - 1);
	end

	// byte ring
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mem[wr_addr] <= in_byte;
		end
		if (cmd.rd) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			cap_q[cap_idx] <= rdata_q;
		end
		if (cmd.j_op == sfrp_pkg::J_CLR) begin
			win_q <= '0;
		end else if (cmd.shift) begin
			win_q <= win_next;
		end
		if (cmd.emit) begin
			pend_q <= ev;
		end
		if ((cmd.emit && pend_v_q) || cmd.flush) begin
			out_q <= pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q       <= '0;
			status_cmd_q  <= '0;
			max_payload_q <= 16'hffff;
			head_q        <= '0;
			fill_q        <= '0;
			j_q           <= '0;
			pend_v_q      <= 1'b0;
			out_v_q       <= 1'b0;
			out_last_q    <= 1'b0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					sfrp_pkg::REG_MAGIC:   magic_q       <= wr_data;
					sfrp_pkg::REG_COMMAND: status_cmd_q  <= wr_data[7:0];
					sfrp_pkg::REG_MAX_LEN: max_payload_q <= wr_data[15:0];
					default: ;
				endcase
			end
			if (cmd.accept) begin
				if (stat.full) begin
					head_q <= head_q + 5'd1;
				end else begin
					fill_q <= fill_q + 6'd1;
				end
			end else if (cmd.drop != sfrp_pkg::DROP_NONE) begin
				head_q <= head_q + amt[sfrp_pkg::PTR_W-1:0];
				fill_q <= fill_q - amt;
			end
			case (cmd.j_op)
				sfrp_pkg::J_CLR:  j_q <= '0;
				sfrp_pkg::J_INC:  j_q <= j_q + 6'd1;
				sfrp_pkg::J_SET4: j_q <= sfrp_pkg::FILL_W'(sfrp_pkg::MAGIC_BYTES);
				sfrp_pkg::J_SET8: j_q <= sfrp_pkg::FILL_W'(sfrp_pkg::HDR_BYTES);
				default: ;
			endcase
			// event hold: an item leaves only once it is known whether it is the last
			if (events.valid && events.ready) begin
				out_v_q <= 1'b0;
			end
			if (cmd.emit) begin
				pend_v_q <= 1'b1;
				if (pend_v_q) begin
					out_v_q    <= 1'b1;
					out_last_q <= 1'b0;
				end
			end else if (cmd.flush) begin
				pend_v_q   <= 1'b0;
				out_v_q    <= 1'b1;
				out_last_q <= 1'b1;
			end
		end
	end

	assign events.valid         = out_v_q;
	assign events.event_kind    = out_q.kind;
	assign events.noise_count   = out_q.noise;
	assign events.sequence_res  = out_q.seq;
	assign events.buttons       = out_q.buttons;
	assign events.trigger_l     = out_q.lt;
	assign events.trigger_r     = out_q.rt;
	assign events.left_x        = $signed(out_q.lx);
	assign events.left_y        = $signed(out_q.ly);
	assign events.right_x       = $signed(out_q.rx);
	assign events.right_y       = $signed(out_q.ry);
	assign events.last_event    = out_last_q;

endmodule

### hw/rtl/sfrp_ctrl.sv
// ----------------------------------------------------------------------------
// sfrp_ctrl: parser sequencer
// Steps the datapath through scan, header check, checksum and event flush.
// ----------------------------------------------------------------------------
module sfrp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  sfrp_pkg::stat_t  stat,
	output sfrp_pkg::cmd_t   cmd
);

	sfrp_pkg::state_t state_q;
	sfrp_pkg::state_t state_next;
	logic             hdr_bad;

	assign hdr_bad = stat.len_over || stat.cmd_bad || stat.len_bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfrp_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			sfrp_pkg::ST_IDLE: begin
				if (in_valid) state_next = sfrp_pkg::ST_SCAN_RD;
			end
			sfrp_pkg::ST_SCAN_RD: begin
				state_next = stat.j_at_fill ? sfrp_pkg::ST_NOMATCH : sfrp_pkg::ST_SCAN_CMP;
			end
			sfrp_pkg::ST_SCAN_CMP: begin
				state_next = stat.hit ? sfrp_pkg::ST_FOUND : sfrp_pkg::ST_SCAN_RD;
			end
			sfrp_pkg::ST_NOMATCH: begin
				if (!stat.disc_nz || stat.room) state_next = sfrp_pkg::ST_FLUSH;
			end
			sfrp_pkg::ST_FOUND: begin
				if (!stat.pos_nz || stat.room) begin
					state_next = stat.rem_short ? sfrp_pkg::ST_FLUSH : sfrp_pkg::ST_FRM_RD;
				end
			end
			sfrp_pkg::ST_FRM_RD: begin
				state_next = sfrp_pkg::ST_FRM_CAP;
			end
			sfrp_pkg::ST_FRM_CAP: begin
				if (stat.j_hdr_end) begin
					state_next = sfrp_pkg::ST_CHECK;
				end else if (stat.j_frm_end) begin
					state_next = sfrp_pkg::ST_SUM;
				end else begin
					state_next = sfrp_pkg::ST_FRM_RD;
				end
			end
			sfrp_pkg::ST_CHECK: begin
				if (hdr_bad) begin
					if (stat.room) state_next = sfrp_pkg::ST_LOOP;
				end else begin
					state_next = stat.frame_short ? sfrp_pkg::ST_FLUSH : sfrp_pkg::ST_FRM_RD;
				end
			end
			sfrp_pkg::ST_SUM: begin
				if (stat.room) state_next = sfrp_pkg::ST_LOOP;
			end
			sfrp_pkg::ST_LOOP: begin
				state_next = stat.fill_zero ? sfrp_pkg::ST_FLUSH : sfrp_pkg::ST_SCAN_RD;
			end
			sfrp_pkg::ST_FLUSH: begin
				if (!stat.pend_v || stat.out_free) state_next = sfrp_pkg::ST_IDLE;
			end
			default: state_next = sfrp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.kind = sfrp_pkg::KIND_NOISE;
		in_ready = 1'b0;
		unique case (state_q)
			sfrp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					cmd.j_op   = sfrp_pkg::J_CLR;
					if (stat.full) begin
						cmd.emit = 1'b1;
						cmd.drop = sfrp_pkg::DROP_ONE;
					end
				end
			end
			sfrp_pkg::ST_SCAN_RD: begin
				cmd.rd = !stat.j_at_fill;
			end
			sfrp_pkg::ST_SCAN_CMP: begin
				cmd.shift = 1'b1;
				if (!stat.hit) cmd.j_op = sfrp_pkg::J_INC;
			end
			sfrp_pkg::ST_NOMATCH: begin
				if (stat.disc_nz && stat.room) begin
					cmd.emit = 1'b1;
					cmd.drop = sfrp_pkg::DROP_DISC;
				end
			end
			sfrp_pkg::ST_FOUND: begin
				if (!stat.pos_nz || stat.room) begin
					cmd.j_op = sfrp_pkg::J_SET4;
					if (stat.pos_nz) begin
						cmd.emit = 1'b1;
						cmd.drop = sfrp_pkg::DROP_POS;
					end
				end
			end
			sfrp_pkg::ST_FRM_RD: begin
				cmd.rd = 1'b1;
			end
			sfrp_pkg::ST_FRM_CAP: begin
				cmd.cap = 1'b1;
				if (!stat.j_hdr_end && !stat.j_frm_end) cmd.j_op = sfrp_pkg::J_INC;
			end
			sfrp_pkg::ST_CHECK: begin
				if (hdr_bad) begin
					if (stat.room) begin
						cmd.emit = 1'b1;
						cmd.drop = sfrp_pkg::DROP_ONE;
						if (stat.len_over) begin
							cmd.kind = sfrp_pkg::KIND_OVERSIZE;
						end else if (stat.cmd_bad) begin
							cmd.kind = sfrp_pkg::KIND_COMMAND;
						end else begin
							cmd.kind = sfrp_pkg::KIND_LENGTH;
						end
					end
				end else begin
					cmd.j_op = sfrp_pkg::J_SET8;
				end
			end
			sfrp_pkg::ST_SUM: begin
				if (stat.room) begin
					cmd.emit = 1'b1;
					if (stat.sum_bad) begin
						cmd.kind = sfrp_pkg::KIND_CHECKSUM;
						cmd.drop = sfrp_pkg::DROP_ONE;
					end else begin
						cmd.kind = sfrp_pkg::KIND_STATUS;
						cmd.drop = sfrp_pkg::DROP_FRAME;
					end
				end
			end
			sfrp_pkg::ST_LOOP: begin
				cmd.j_op = sfrp_pkg::J_CLR;
			end
			sfrp_pkg::ST_FLUSH: begin
				cmd.flush = stat.pend_v && stat.out_free;
			end
			default: ;
		endcase
	end

endmodule

### hw/rtl/status_frame_resync_parser.sv
// ----------------------------------------------------------------------------
// status_frame_resync_parser: resynchronizing status frame parser
// Buffers received bytes, hunts for the magic, checks header and checksum
// and reports every decision as an event item.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake     payload
// rx        in         valid/ready   rx_byte
// events    out        valid/ready   event_kind .. right_y, last_event
// wr_*      in         wr_en only    wr_index, wr_data (no read-back)
//
// one byte at a time: a byte is taken only with the sequencer idle
// magic scan reads and compares each buffered byte in turn (one ring read port), then a
// header read, a header check and a checksum walk over the rest of the frame
// each rejection drops one byte and rescans
// reset clears fill level, pointers and event valids; ring contents stay
// a stalled event channel holds the sequencer once the hold register is full
//
module status_frame_resync_parser #(
	parameter int BUFFER_BYTES = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	sfrp_byte_if.sink                       rx,
	sfrp_event_if.source                    events,
	input  logic                            wr_en,
	input  logic [sfrp_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [sfrp_pkg::CFG_DATA_W-1:0] wr_data
);

	sfrp_pkg::cmd_t  cmd;
	sfrp_pkg::stat_t stat;
	logic            in_ready;

	assign rx.ready = in_ready;

	// sequencer
	sfrp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// ring buffer, scan window, frame capture and event registers
	sfrp_datapath #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_byte  (rx.rx_byte),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cmd      (cmd),
		.stat     (stat),
		.events   (events)
	);

endmodule

### hw/rtl/sfrp_checker.sv
// ----------------------------------------------------------------------------
// sfrp_checker: port-level checks of the status frame parser
// Watches the event channel for consistent event items.
// ----------------------------------------------------------------------------
module sfrp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       ev_valid,
	input logic       ev_ready,
	input logic [2:0] ev_kind,
	input logic [5:0] ev_noise
);

	// noise items always carry a count
	a_noise_count: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && ev_kind == sfrp_pkg::KIND_NOISE |-> ev_noise != 6'd0)
		else $error("noise event without count");

	// other items carry none
	a_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && ev_kind != sfrp_pkg::KIND_NOISE |-> ev_noise == 6'd0)
		else $error("count on non-noise event");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid |-> ev_kind <= sfrp_pkg::KIND_CHECKSUM)
		else $error("undefined event kind");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && !ev_ready |=> ev_valid && $stable(ev_kind) && $stable(ev_noise))
		else $error("stalled event changed");

endmodule

bind status_frame_resync_parser sfrp_checker u_sfrp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.ev_valid (events.valid),
	.ev_ready (events.ready),
	.ev_kind  (events.event_kind),
	.ev_noise (events.noise_count)
);

### tb/sfrp_checker.sv
// ----------------------------------------------------------------------------
// sfrp_scoreboard: event predictor and scoreboard of the status frame parser
// Watches the byte and event channels, predicts the event items of each
// accepted byte and compares them field by field with what the block sends.
// ----------------------------------------------------------------------------
module sfrp_scoreboard (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	input  logic        rx_ready,
	input  logic [7:0]  rx_byte,
	input  logic        ev_valid,
	input  logic        ev_ready,
	input  logic [2:0]  ev_kind,
	input  logic [5:0]  ev_noise,
	input  logic [7:0]  ev_seq,
	input  logic [15:0] ev_buttons,
	input  logic [15:0] ev_lt,
	input  logic [15:0] ev_rt,
	input  logic [15:0] ev_lx,
	input  logic [15:0] ev_ly,
	input  logic [15:0] ev_rx,
	input  logic [15:0] ev_ry,
	input  logic        ev_last,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [31:0] wr_data,
	output int          fail_count,
	output int          pending,
	output int          status_seen,
	output int          error_seen
);

	typedef struct packed {
		sfrp_pkg::evt_t e;
		logic last;
	} exp_evt_t;

	logic [7:0]  held [0:63];
	int          held_n;
	logic [31:0] magic_r;
	logic [7:0]  cmd_r;
	logic [15:0] max_len_r;
	exp_evt_t    expected_q [$];

	function automatic logic [7:0] magic_byte(int k);
		return magic_r[8*k +: 8];
	endfunction

	function automatic void drop_bytes(int cnt);
		if (cnt >= held_n) begin
			held_n = 0;
		end else begin
			for (int i = 0; i < held_n - cnt; i++) held[i] = held[i + cnt];
			held_n -= cnt;
		end
	endfunction

	function automatic void push_evt(sfrp_pkg::kind_t kind, int noise, ref int n);
		exp_evt_t x;
		if (n >= 64) return;
		x = '0;
		x.e.kind  = kind;
		x.e.noise = noise[5:0];
		if (kind == sfrp_pkg::KIND_STATUS) begin
			x.e.seq     = held[4];
			x.e.buttons = {held[9], held[8]};
			x.e.lt      = {held[11], held[10]};
			x.e.rt      = {held[13], held[12]};
			x.e.lx      = {held[15], held[14]};
			x.e.ly      = {held[17], held[16]};
			x.e.rx      = {held[19], held[18]};
			x.e.ry      = {held[21], held[20]};
		end
		expected_q.push_back(x);
		n++;
	endfunction

	// predicts the events of one byte and queues them
	function automatic void parse_byte(logic [7:0] b);
		int n, pos, keep, len;
		bit hit, same;
		logic [7:0] sum;
		n = 0;
		if (held_n >= sfrp_pkg::MEM_DEPTH) begin
			push_evt(sfrp_pkg::KIND_NOISE, 1, n);
			drop_bytes(1);
		end
		held[held_n] = b;
		held_n++;
		while (held_n != 0) begin
			pos = held_n;
			for (int i = 0; i + 4 <= held_n; i++) begin
				hit = 1;
				for (int k = 0; k < 4; k++)
					if (held[i + k] != magic_byte(k)) hit = 0;
				if (hit) begin
					pos = i;
					break;
				end
			end
			if (pos == held_n) begin
				keep = held_n < 3 ? held_n : 3;
				while (keep != 0) begin
					same = 1;
					for (int k = 0; k < keep; k++)
						if (held[held_n - keep + k] != magic_byte(k)) same = 0;
					if (same) break;
					keep--;
				end
				if (held_n - keep != 0) push_evt(sfrp_pkg::KIND_NOISE, held_n - keep, n);
				drop_bytes(held_n - keep);
				break;
			end
			if (pos != 0) begin
				push_evt(sfrp_pkg::KIND_NOISE, pos, n);
				drop_bytes(pos);
			end
			if (held_n < sfrp_pkg::HDR_BYTES) break;
			len = int'({held[7], held[6]});
			if (len > max_len_r) begin
				push_evt(sfrp_pkg::KIND_OVERSIZE, 0, n);
				drop_bytes(1);
				continue;
			end
			if (held[5] != cmd_r) begin
				push_evt(sfrp_pkg::KIND_COMMAND, 0, n);
				drop_bytes(1);
				continue;
			end
			if (len != sfrp_pkg::STATUS_PAYLOAD_BYTES) begin
				push_evt(sfrp_pkg::KIND_LENGTH, 0, n);
				drop_bytes(1);
				continue;
			end
			if (held_n < sfrp_pkg::FRAME_BYTES) break;
			sum = '0;
			for (int i = 4; i < sfrp_pkg::FRAME_BYTES - 1; i++) sum ^= held[i];
			if (sum != held[sfrp_pkg::FRAME_BYTES - 1]) begin
				push_evt(sfrp_pkg::KIND_CHECKSUM, 0, n);
				drop_bytes(1);
				continue;
			end
			push_evt(sfrp_pkg::KIND_STATUS, 0, n);
			drop_bytes(sfrp_pkg::FRAME_BYTES);
		end
		if (n > 0) expected_q[$].last = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		exp_evt_t x;
		if (!arst_n) begin
			held_n = 0;
			magic_r = '0;
			cmd_r = '0;
			max_len_r = 16'hffff;
			fail_count = 0;
			status_seen = 0;
			error_seen = 0;
			expected_q.delete();
		end else begin
			if (wr_en) begin
				case (wr_index)
					sfrp_pkg::REG_MAGIC: magic_r = wr_data;
					sfrp_pkg::REG_COMMAND: cmd_r = wr_data[7:0];
					sfrp_pkg::REG_MAX_LEN: max_len_r = wr_data[15:0];
					default: ;
				endcase
			end
			// compare before predicting: a byte's events come out later
			if (ev_valid && ev_ready) begin
				if (expected_q.size() == 0) begin
					$error("event item with nothing expected, kind %0d", ev_kind);
					fail_count++;
				end else begin
					x = expected_q.pop_front();
					if (x.e.kind == sfrp_pkg::KIND_STATUS) status_seen++;
					else if (x.e.kind != sfrp_pkg::KIND_NOISE) error_seen++;
					if (ev_kind !== x.e.kind) begin
						$error("event_kind exp %0d got %0d", x.e.kind, ev_kind); fail_count++;
					end
					if (ev_noise !== x.e.noise) begin
						$error("noise_count exp %0d got %0d", x.e.noise, ev_noise); fail_count++;
					end
					if (ev_seq !== x.e.seq) begin
						$error("sequence_res exp %0h got %0h", x.e.seq, ev_seq); fail_count++;
					end
					if (ev_buttons !== x.e.buttons) begin
						$error("buttons exp %0h got %0h", x.e.buttons, ev_buttons); fail_count++;
					end
					if (ev_lt !== x.e.lt) begin
						$error("trigger_l exp %0h got %0h", x.e.lt, ev_lt); fail_count++;
					end
					if (ev_rt !== x.e.rt) begin
						$error("trigger_r exp %0h got %0h", x.e.rt, ev_rt); fail_count++;
					end
					if (ev_lx !== x.e.lx) begin
						$error("left_x exp %0h got %0h", x.e.lx, ev_lx); fail_count++;
					end
					if (ev_ly !== x.e.ly) begin
						$error("left_y exp %0h got %0h", x.e.ly, ev_ly); fail_count++;
					end
					if (ev_rx !== x.e.rx) begin
						$error("right_x exp %0h got %0h", x.e.rx, ev_rx); fail_count++;
					end
					if (ev_ry !== x.e.ry) begin
						$error("right_y exp %0h got %0h", x.e.ry, ev_ry); fail_count++;
					end
					if (ev_last !== x.last) begin
						$error("last_event exp %0d got %0d", x.last, ev_last); fail_count++;
					end
				end
			end
			if (rx_valid && rx_ready) parse_byte(rx_byte);
		end
		pending = expected_q.size();
	end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the status frame resync parser
// Sends directed and random byte streams of good and broken frames under
// several register settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;

	localparam int IDLE_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [1:0]  wr_index;
	logic [31:0] wr_data;
	int          fail_count, pending, status_seen, error_seen;
	int          bytes_sent;
	int          idle_cycles;
	bit          long_hold;
	bit          finished;

	// current settings, mirrored so the stimulus can build matching frames
	logic [31:0] cur_magic;
	logic [7:0]  cur_cmd;

	sfrp_byte_if  rx_ch();
	sfrp_event_if ev_ch();

	status_frame_resync_parser u_dut (
		.clk(clk), .arst_n(arst_n), .rx(rx_ch.sink), .events(ev_ch.source),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	sfrp_scoreboard u_chk (
		.clk(clk), .arst_n(arst_n),
		.rx_valid(rx_ch.valid), .rx_ready(rx_ch.ready), .rx_byte(rx_ch.rx_byte),
		.ev_valid(ev_ch.valid), .ev_ready(ev_ch.ready), .ev_kind(ev_ch.event_kind),
		.ev_noise(ev_ch.noise_count), .ev_seq(ev_ch.sequence_res),
		.ev_buttons(ev_ch.buttons), .ev_lt(ev_ch.trigger_l),
		.ev_rt(ev_ch.trigger_r), .ev_lx(ev_ch.left_x), .ev_ly(ev_ch.left_y),
		.ev_rx(ev_ch.right_x), .ev_ry(ev_ch.right_y), .ev_last(ev_ch.last_event),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.fail_count(fail_count), .pending(pending),
		.status_seen(status_seen), .error_seen(error_seen)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// event side: random stall per item, one long hold-off to back up the block
	initial begin
		int gap;
		ev_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				ev_ch.ready <= 0;
				repeat (600) @(posedge clk);
				long_hold = 0;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				ev_ch.ready <= 0;
				repeat (gap) @(posedge clk);
			end
			ev_ch.ready <= 1;
			@(posedge clk);
			while (!ev_ch.valid) @(posedge clk);
		end
	end

	// watchdog: cycles with neither channel moving
	always @(posedge clk) begin
		if ((rx_ch.valid && rx_ch.ready) || (ev_ch.valid && ev_ch.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT && !finished) begin
			$display("tb failed");
			$finish;
		end
	end

	// valid stays up between back-to-back items; drain and write_reg drop it
	task automatic send_byte(input logic [7:0] b, input bit burst);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			rx_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid   <= 1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		rx_ch.valid <= 0;
		wr_en    <= 1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 0;
		if (idx == sfrp_pkg::REG_MAGIC) cur_magic = val;
		if (idx == sfrp_pkg::REG_COMMAND) cur_cmd = val[7:0];
	endtask

	// waits for every expected item and lets the sequencer settle
	task automatic drain();
		rx_ch.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	// flaw: 0 good, 1 oversize, 2 wrong command, 3 wrong length, 4 bad checksum
	task automatic send_frame(input int flaw, input bit extreme, input bit burst);
		logic [7:0] f [0:sfrp_pkg::FRAME_BYTES-1];
		logic [7:0] sum;
		for (int k = 0; k < 4; k++) f[k] = cur_magic[8*k +: 8];
		f[4] = 8'($urandom);
		f[5] = cur_cmd;
		f[6] = 8'(sfrp_pkg::STATUS_PAYLOAD_BYTES);
		f[7] = 8'h00;
		for (int k = 8; k < sfrp_pkg::FRAME_BYTES - 1; k++)
			f[k] = extreme ? (((k & 2) != 0) ? 8'hff : 8'h00) : 8'($urandom);
		if (flaw == 1) begin f[6] = 8'hff; f[7] = 8'hff; end
		if (flaw == 2) f[5] = cur_cmd ^ (8'h1 << $urandom_range(0, 7));
		if (flaw == 3) f[6] = 8'($urandom_range(0, 13));
		sum = '0;
		for (int k = 4; k < sfrp_pkg::FRAME_BYTES - 1; k++) sum ^= f[k];
		f[sfrp_pkg::FRAME_BYTES - 1] = (flaw == 4) ? ~sum : sum;
		for (int k = 0; k < sfrp_pkg::FRAME_BYTES; k++) send_byte(f[k], burst);
	endtask

	task automatic random_mix(input int items);
		int start, r;
		start = bytes_sent;
		while (bytes_sent - start < items) begin
			r = $urandom_range(0, 9);
			if (r < 6) send_frame(0, 0, $urandom_range(0, 3) == 0);
			else if (r < 8) send_frame($urandom_range(1, 4), 0, 0);
			else repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 0);
		end
	endtask

	initial begin
		rx_ch.valid = 0;
		rx_ch.rx_byte = 0;
		wr_en = 0;
		wr_index = 0;
		wr_data = 0;
		arst_n = 0;
		bytes_sent = 0;
		idle_cycles = 0;
		long_hold = 0;
		finished = 0;
		cur_magic = 0;
		cur_cmd = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset settings: magic of zeros, command zero
		send_frame(0, 1, 0);
		repeat (3) send_byte(8'h00, 0);
		drain();

		// directed: each flaw, noise before the magic, partial magic tail
		write_reg(sfrp_pkg::REG_MAGIC, 32'hfeedc0de);
		write_reg(sfrp_pkg::REG_COMMAND, 32'h000000ff);
		send_byte(8'h55, 0);
		send_byte(8'hde, 0);
		send_byte(8'hc0, 0);
		send_frame(0, 1, 0);
		for (int fl = 1; fl <= 4; fl++) send_frame(fl, 0, 0);
		drain();

		// magic of all ones: a run of ones keeps matching and failing the header
		write_reg(sfrp_pkg::REG_MAGIC, 32'hffffffff);
		write_reg(sfrp_pkg::REG_COMMAND, 32'h00000000);
		repeat (8) send_byte(8'hff, 1);
		send_frame(0, 0, 0);
		drain();

		// random phases with varied settings, a long event stall in the first
		write_reg(sfrp_pkg::REG_MAGIC, $urandom);
		write_reg(sfrp_pkg::REG_COMMAND, $urandom);
		write_reg(sfrp_pkg::REG_MAX_LEN, $urandom_range(14, 65535));
		long_hold = 1;
		random_mix(10);
		drain();
		write_reg(sfrp_pkg::REG_MAGIC, {8'($urandom_range(0, 255)), 24'h5a5a5a});
		write_reg(sfrp_pkg::REG_COMMAND, 32'h00000081);
		write_reg(sfrp_pkg::REG_MAX_LEN, 32'd14);
		random_mix(10);
		drain();

		finished = 1;
		$display("bytes sent %0d, status frames %0d, rejected frames %0d",
			bytes_sent, status_seen, error_seen);
		if (fail_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

### files.f
hw/rtl/sfrp_pkg.sv
hw/rtl/sfrp_if.sv
hw/rtl/sfrp_datapath.sv
hw/rtl/sfrp_ctrl.sv
hw/rtl/status_frame_resync_parser.sv
hw/rtl/sfrp_checker.sv
tb/sfrp_checker.sv
tb/tb.sv
